@@ rtl/pid_controller_antiwindup_macros.svh @@
// Assertion macros shared by the PID controller RTL.
`ifndef PID_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCA_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pid controller: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pid controller: next-cycle check failed");

`endif

@@ rtl/pca_pkg.sv @@
// Types, codes and helper functions shared by the PID controller modules.
`default_nettype none

package pca_pkg;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic        [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               updated;
    logic               clamped;
  } result_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_DIV   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD     = 3'd7;

  // Divider geometry: 48-bit dividend, 32-bit divisor, two quotient bits per step.
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_STEPS = DIV_NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_CHECK     = 5'd2;
  localparam op_t OP_DIV_T     = 5'd3;
  localparam op_t OP_DT        = 5'd4;
  localparam op_t OP_SEL_P     = 5'd5;
  localparam op_t OP_SEL_INC   = 5'd6;
  localparam op_t OP_SEL_I     = 5'd7;
  localparam op_t OP_SEL_D     = 5'd8;
  localparam op_t OP_MUL_LO    = 5'd9;
  localparam op_t OP_MUL_HI    = 5'd10;
  localparam op_t OP_ACC_FIRST = 5'd11;
  localparam op_t OP_ACC_SHIFT = 5'd12;
  localparam op_t OP_WB_P      = 5'd13;
  localparam op_t OP_WB_INC    = 5'd14;
  localparam op_t OP_WB_I      = 5'd15;
  localparam op_t OP_WB_D      = 5'd16;
  localparam op_t OP_DIV_D     = 5'd17;
  localparam op_t OP_DERIV     = 5'd18;
  localparam op_t OP_ADD       = 5'd19;
  localparam op_t OP_CLAMP     = 5'd20;
  localparam op_t OP_EMIT      = 5'd21;
  localparam op_t OP_HOLD      = 5'd22;

  typedef struct packed {
    op_t op;
  } pca_cmd_t;

  typedef struct packed {
    logic held;
    logic dt_zero;
    logic div_done;
    logic out_free;
  } pca_status_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [47:0] abs48(input logic [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  // Apply a sign to a magnitude and saturate to 32-bit signed.
  function automatic logic [31:0] sat_mag32(input logic [63:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) r = 32'h8000_0000;
      else r = ~m[31:0] + 32'd1;
    end else begin
      if (m > 64'h0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

  // Output direction; negating the most negative value saturates.
  function automatic logic [31:0] apply_dir(input logic [31:0] v, input logic rev);
    logic [31:0] r;
    if (!rev) r = v;
    else if (v == 32'h8000_0000) r = 32'h7FFF_FFFF;
    else r = ~v + 32'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pca_div.sv @@
// Iterative unsigned divider, two quotient bits per clock.
`default_nettype none

module pca_div
  import pca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] qn;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   s1;
  logic [DIV_DEN_W:0]   s2;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [DIV_DEN_W:0] div_step(input logic [DIV_DEN_W-1:0] r,
                                                  input logic b,
                                                  input logic [DIV_DEN_W-1:0] d);
    logic [DIV_DEN_W+1:0] diff;
    logic [DIV_DEN_W:0]   res;
    diff = {1'b0, r, b} - {2'b00, d};
    if (!diff[DIV_DEN_W+1]) res = {1'b1, diff[DIV_DEN_W-1:0]};
    else res = {1'b0, r[DIV_DEN_W-2:0], b};
    return res;
  endfunction

  always_comb begin
    s1 = div_step(rem, qn[DIV_NUM_W-1], den_r);
    s2 = div_step(s1[DIV_DEN_W-1:0], qn[DIV_NUM_W-2], den_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      qn  <= {qn[DIV_NUM_W-3:0], s1[DIV_DEN_W], s2[DIV_DEN_W]};
      rem <= s2[DIV_DEN_W-1:0];
    end
  end

  assign quot = qn;

endmodule

`default_nettype wire

@@ rtl/pca_ctrl.sv @@
// Sequencer that steps the PID datapath through one update.
`default_nettype none

module pca_ctrl
  import pca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  input  pca_status_t status,
  output pca_cmd_t    cmd,
  output logic        sample_stall
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHECK   = 5'd1;
  localparam logic [4:0] S_TDIV_GO = 5'd2;
  localparam logic [4:0] S_TDIV    = 5'd3;
  localparam logic [4:0] S_DT      = 5'd4;
  localparam logic [4:0] S_SEL_P   = 5'd5;
  localparam logic [4:0] S_MUL_P   = 5'd6;
  localparam logic [4:0] S_ACC_P   = 5'd7;
  localparam logic [4:0] S_WB_P    = 5'd8;
  localparam logic [4:0] S_SEL_INC = 5'd9;
  localparam logic [4:0] S_MUL_INC = 5'd10;
  localparam logic [4:0] S_ACC_INC = 5'd11;
  localparam logic [4:0] S_WB_INC  = 5'd12;
  localparam logic [4:0] S_SEL_I   = 5'd13;
  localparam logic [4:0] S_MUL_IH  = 5'd14;
  localparam logic [4:0] S_ACC_IH  = 5'd15;
  localparam logic [4:0] S_MUL_IL  = 5'd16;
  localparam logic [4:0] S_ACC_IL  = 5'd17;
  localparam logic [4:0] S_WB_I    = 5'd18;
  localparam logic [4:0] S_DDIV_GO = 5'd19;
  localparam logic [4:0] S_DDIV    = 5'd20;
  localparam logic [4:0] S_DERIV   = 5'd21;
  localparam logic [4:0] S_SEL_D   = 5'd22;
  localparam logic [4:0] S_MUL_D   = 5'd23;
  localparam logic [4:0] S_ACC_D   = 5'd24;
  localparam logic [4:0] S_WB_D    = 5'd25;
  localparam logic [4:0] S_ADD     = 5'd26;
  localparam logic [4:0] S_CLAMP   = 5'd27;
  localparam logic [4:0] S_EMIT    = 5'd28;
  localparam logic [4:0] S_HOLD    = 5'd29;

  logic [4:0] state;
  logic [4:0] state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = status.held ? S_HOLD : S_TDIV_GO;
      end
      S_TDIV_GO: begin
        cmd.op     = OP_DIV_T;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        if (status.div_done) state_next = S_DT;
      end
      S_DT: begin
        cmd.op     = OP_DT;
        state_next = S_SEL_P;
      end
      S_SEL_P: begin
        cmd.op     = OP_SEL_P;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_ACC_P;
      end
      S_ACC_P: begin
        cmd.op     = OP_ACC_FIRST;
        state_next = S_WB_P;
      end
      S_WB_P: begin
        cmd.op     = OP_WB_P;
        state_next = S_SEL_INC;
      end
      S_SEL_INC: begin
        cmd.op     = OP_SEL_INC;
        state_next = S_MUL_INC;
      end
      S_MUL_INC: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_ACC_INC;
      end
      S_ACC_INC: begin
        cmd.op     = OP_ACC_FIRST;
        state_next = S_WB_INC;
      end
      S_WB_INC: begin
        cmd.op     = OP_WB_INC;
        state_next = S_SEL_I;
      end
      S_SEL_I: begin
        cmd.op     = OP_SEL_I;
        state_next = S_MUL_IH;
      end
      // The integral term is 32 x 48 bits: upper 16 bits first, then the lower 32.
      S_MUL_IH: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_ACC_IH;
      end
      S_ACC_IH: begin
        cmd.op     = OP_ACC_FIRST;
        state_next = S_MUL_IL;
      end
      S_MUL_IL: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_ACC_IL;
      end
      S_ACC_IL: begin
        cmd.op     = OP_ACC_SHIFT;
        state_next = S_WB_I;
      end
      S_WB_I: begin
        cmd.op     = OP_WB_I;
        // With zero elapsed time the derivative stays zero and the divide is skipped.
        state_next = status.dt_zero ? S_SEL_D : S_DDIV_GO;
      end
      S_DDIV_GO: begin
        cmd.op     = OP_DIV_D;
        state_next = S_DDIV;
      end
      S_DDIV: begin
        if (status.div_done) state_next = S_DERIV;
      end
      S_DERIV: begin
        cmd.op     = OP_DERIV;
        state_next = S_SEL_D;
      end
      S_SEL_D: begin
        cmd.op     = OP_SEL_D;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.op     = OP_ACC_FIRST;
        state_next = S_WB_D;
      end
      S_WB_D: begin
        cmd.op     = OP_WB_D;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_HOLD: begin
        if (status.out_free) begin
          cmd.op     = OP_HOLD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No request is taken while reset is held.
  assign sample_stall = rst || (state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/pca_dp.sv @@
// PID datapath: configuration, loop state, shared multiplier and divider, result register.
`default_nettype none
`include "pid_controller_antiwindup_macros.svh"

module pca_dp
  import pca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  sample_t                sample,
  input  pca_cmd_t               cmd,
  output pca_status_t            status,
  output result_t                result,
  output logic                   result_valid,
  input  logic                   result_stall
);

  localparam logic signed [49:0] S48_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] S48_MIN = -50'sh0_8000_0000_0000;

  // Configuration registers.
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic signed [31:0] lo_limit;
  logic signed [31:0] hi_limit;
  logic               reverse_dir;
  logic        [15:0] time_divisor;
  logic        [15:0] sample_period;

  // Loop state.
  logic        [31:0] last_ms;
  logic signed [47:0] integ;
  logic signed [47:0] integ_before;
  logic signed [31:0] prev_err;
  logic signed [31:0] held_out;

  // Working registers for one update.
  sample_t            smp;
  logic        [31:0] elapsed;
  logic signed [31:0] err;
  logic        [30:0] dt;
  logic signed [32:0] diff;
  logic signed [31:0] deriv;
  logic signed [31:0] p_term;
  logic signed [31:0] i_term;
  logic signed [31:0] d_term;
  logic        [31:0] op_a;
  logic        [47:0] op_b;
  logic               op_neg;
  logic        [63:0] prod;
  logic        [79:0] macc;
  logic signed [33:0] sum;
  logic               clamped;

  // Combinational helpers.
  logic        [31:0]          elapsed_c;
  logic signed [32:0]          err_wide;
  logic signed [31:0]          err_sat;
  logic        [15:0]          time_den;
  logic        [32:0]          diff_mag;
  logic                        div_start;
  logic        [DIV_NUM_W-1:0] div_num;
  logic        [DIV_DEN_W-1:0] div_den;
  logic                        div_busy;
  logic                        div_done;
  logic        [DIV_NUM_W-1:0] div_quot;
  logic        [31:0]          mul_b;
  logic        [63:0]          mag;
  logic        [48:0]          inc_mag;
  logic signed [49:0]          inc_s;
  logic signed [49:0]          integ_sum;
  logic signed [47:0]          integ_sat;
  logic signed [33:0]          hi_ext;
  logic signed [33:0]          lo_ext;

  always_comb begin
    elapsed_c = smp.now_ms - last_ms;
    err_wide  = 33'(smp.target) - 33'(smp.measured);
    if (err_wide > 33'sh0_7FFF_FFFF) err_sat = 32'sh7FFF_FFFF;
    else if (err_wide < -33'sh0_8000_0000) err_sat = 32'sh8000_0000;
    else err_sat = err_wide[31:0];

    time_den = (time_divisor == 16'd0) ? 16'd1 : time_divisor;
    diff_mag = diff[32] ? (~diff + 33'd1) : diff;

    div_start = (cmd.op == OP_DIV_T) || (cmd.op == OP_DIV_D);
    if (cmd.op == OP_DIV_D) begin
      div_num = {diff_mag[31:0], 16'd0};
      div_den = {1'b0, dt};
    end else begin
      div_num = {elapsed, 16'd0};
      div_den = {16'd0, time_den};
    end

    mul_b = (cmd.op == OP_MUL_HI) ? {16'd0, op_b[47:32]} : op_b[31:0];
    mag   = macc[79:16];

    // The integral increment never exceeds 2^46 in magnitude.
    inc_mag   = macc[64:16];
    inc_s     = op_neg ? (50'sd0 - $signed({1'b0, inc_mag})) : $signed({1'b0, inc_mag});
    integ_sum = 50'(integ) + inc_s;
    if (integ_sum > S48_MAX) integ_sat = S48_MAX[47:0];
    else if (integ_sum < S48_MIN) integ_sat = S48_MIN[47:0];
    else integ_sat = integ_sum[47:0];

    hi_ext = 34'(hi_limit);
    lo_ext = 34'(lo_limit);
  end

  pca_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    status.held     = (elapsed_c < {16'd0, sample_period});
    status.dt_zero  = (dt == '0);
    status.div_done = div_done;
    status.out_free = !result_valid || !result_stall;
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        smp <= sample;
      end
      OP_CHECK: begin
        elapsed <= elapsed_c;
        err     <= err_sat;
      end
      OP_DT: begin
        dt    <= (|div_quot[DIV_NUM_W-1:31]) ? 31'h7FFF_FFFF : div_quot[30:0];
        diff  <= 33'(err) - 33'(prev_err);
        deriv <= '0;
      end
      OP_SEL_P: begin
        op_a   <= abs32(gain_p);
        op_b   <= {16'd0, abs32(err)};
        op_neg <= gain_p[31] ^ err[31];
      end
      OP_SEL_INC: begin
        op_a   <= abs32(err);
        op_b   <= {17'd0, dt};
        op_neg <= err[31];
      end
      OP_SEL_I: begin
        op_a   <= abs32(gain_i);
        op_b   <= abs48(integ);
        op_neg <= gain_i[31] ^ integ[47];
      end
      OP_SEL_D: begin
        op_a   <= abs32(gain_d);
        op_b   <= {16'd0, abs32(deriv)};
        op_neg <= gain_d[31] ^ deriv[31];
      end
      OP_MUL_LO, OP_MUL_HI: begin
        prod <= op_a * mul_b;
      end
      OP_ACC_FIRST: begin
        macc <= {16'd0, prod};
      end
      OP_ACC_SHIFT: begin
        macc <= {macc[47:0], 32'd0} + {16'd0, prod};
      end
      OP_WB_P: begin
        p_term <= sat_mag32(mag, op_neg);
      end
      OP_WB_I: begin
        i_term <= sat_mag32(mag, op_neg);
      end
      OP_WB_D: begin
        d_term <= sat_mag32(mag, op_neg);
      end
      OP_DERIV: begin
        deriv <= sat_mag32({16'd0, div_quot}, diff[32]);
      end
      OP_ADD: begin
        sum <= 34'(p_term) + 34'(i_term) + 34'(d_term);
      end
      default: begin
      end
    endcase
  end

  // Configuration and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      lo_limit      <= '0;
      hi_limit      <= 32'sh00FF_0000;
      reverse_dir   <= 1'b0;
      time_divisor  <= 16'd1000;
      sample_period <= 16'd100;
      last_ms       <= '0;
      integ         <= '0;
      integ_before  <= '0;
      prev_err      <= '0;
      held_out      <= '0;
      clamped       <= 1'b0;
    end else begin
      case (cmd.op)
        OP_DT: begin
          last_ms <= smp.now_ms;
        end
        OP_WB_INC: begin
          integ_before <= integ;
          integ        <= integ_sat;
        end
        OP_CLAMP: begin
          prev_err <= err;
          // The high limit is tested first, so it wins when the limits cross.
          if (sum > hi_ext) begin
            held_out <= hi_limit;
            integ    <= integ_before;
            clamped  <= 1'b1;
          end else if (sum < lo_ext) begin
            held_out <= lo_limit;
            integ    <= integ_before;
            clamped  <= 1'b1;
          end else begin
            held_out <= sum[31:0];
            clamped  <= 1'b0;
          end
        end
        default: begin
        end
      endcase

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GAIN_P: begin
            gain_p   <= cfg_data;
            integ    <= '0;
            prev_err <= '0;
          end
          REG_GAIN_I: begin
            gain_i   <= cfg_data;
            integ    <= '0;
            prev_err <= '0;
          end
          REG_GAIN_D: begin
            gain_d   <= cfg_data;
            integ    <= '0;
            prev_err <= '0;
          end
          REG_LOW_LIMIT:  lo_limit      <= cfg_data;
          REG_HIGH_LIMIT: hi_limit      <= cfg_data;
          REG_REVERSE:    reverse_dir   <= cfg_data[0];
          REG_TIME_DIV:   time_divisor  <= cfg_data[15:0];
          REG_PERIOD:     sample_period <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result register: the next request is taken while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.op == OP_EMIT) || (cmd.op == OP_HOLD)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      result.drive   <= apply_dir(held_out, reverse_dir);
      result.updated <= 1'b1;
      result.clamped <= clamped;
    end else if (cmd.op == OP_HOLD) begin
      result.drive   <= apply_dir(held_out, reverse_dir);
      result.updated <= 1'b0;
      result.clamped <= 1'b0;
    end
  end

  `PCA_ASSERT_NEXT(a_held_in_limits, clk, rst, (cmd.op == OP_CLAMP) && (lo_limit <= hi_limit), (held_out >= lo_limit) && (held_out <= hi_limit))
  `PCA_ASSERT_IMPL(a_deriv_div_nonzero, clk, rst, cmd.op == OP_DIV_D, dt != '0)
  `PCA_ASSERT_IMPL(a_div_start_idle, clk, rst, div_start, !div_busy)
  `PCA_ASSERT_IMPL(a_emit_has_room, clk, rst, (cmd.op == OP_EMIT) || (cmd.op == OP_HOLD), !result_valid || !result_stall)

endmodule

`default_nettype wire

@@ rtl/pid_controller_antiwindup.sv @@
// Top level of the Q16.16 PID controller with anti-windup.
`default_nettype none

// One request at a time. A request that falls inside the sample period places
// the held output (direction applied) in the output register through the
// check state and then the hold state. A full update runs the two radix-4
// divides of 24 steps (elapsed time scaling, then derivative) on one shared
// divider, skipping the derivative divide when the elapsed time is zero, and
// makes five passes through a single 32x32 multiplier before its result is
// placed there. A stalled output register delays the result by the length of
// the stall. A new request is accepted from the cycle after the previous
// result has been written to the output register. Configuration writes are
// registered and must only be made while no request is in progress.
module pid_controller_antiwindup
  import pca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  pca_cmd_t    cmd;
  pca_status_t status;

  pca_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .status       (status),
    .cmd          (cmd),
    .sample_stall (sample_stall)
  );

  pca_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire
